### rtl/core/kmcq_pkg.sv
// Package with shared types and constants for the colour quantiser.
`default_nettype none
package kmcq_pkg;
  localparam int unsigned MaxK = 8;
  localparam int unsigned MaxPixels = 1048576;
  localparam int unsigned SumW = 28;
  localparam int unsigned CntW = 21;

  localparam logic [1:0] ReqLoad = 2'd0;
  localparam logic [1:0] ReqPixel = 2'd1;
  localparam logic [1:0] ReqUpdate = 2'd2;

  localparam logic KindPixel = 1'b0;
  localparam logic KindCentroid = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] cluster_select;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic [2:0] cluster_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_result;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;    // latch the accepted item
    logic       load;       // write one centroid from the item
    logic       dist_clear; // restart the nearest search
    logic       dist_step;  // compare one centroid
    logic       accum;      // add pixel to the winner's sums
    logic       emit_pixel;
    logic       div_start;  // begin dividing the current cluster
    logic       div_step;
    logic       write_mean; // store mean and emit it
    logic       clear_sums;
    logic [2:0] idx;        // centroid under work
    logic       last;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

### rtl/core/kmcq_ctrl.sv
// Controller sequencing load, classify and update transactions.
`default_nettype none
module kmcq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  kmcq_pkg::item_t    item,
  input  logic [3:0]         k_eff,
  input  kmcq_pkg::stat_t    stat,
  output logic               busy,
  output kmcq_pkg::ctrl_t    ctrl
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIST = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] idx, idx_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= 3'd0;
    end else begin
      state <= state_next;
      idx <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    ctrl = '0;
    ctrl.idx = idx;
    ctrl.last = ({1'b0, idx} + 4'd1 == k_eff);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.capture = 1'b1;
          idx_next = 3'd0;
          priority case (item.req_type)
            kmcq_pkg::ReqLoad: ctrl.load = 1'b1;
            kmcq_pkg::ReqPixel: begin
              ctrl.dist_clear = 1'b1;
              state_next = S_DIST;
            end
            kmcq_pkg::ReqUpdate: state_next = S_DSTART;
            default: ;
          endcase
        end
      end
      S_DIST: begin
        ctrl.dist_step = 1'b1;
        if (ctrl.last) state_next = S_EMIT;
        else idx_next = idx + 3'd1;
      end
      S_EMIT: begin
        ctrl.accum = 1'b1;
        ctrl.emit_pixel = 1'b1;
        state_next = S_IDLE;
      end
      S_DSTART: begin
        ctrl.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctrl.div_step = 1'b1;
        if (stat.div_done) state_next = S_WRITE;
      end
      S_WRITE: begin
        ctrl.write_mean = 1'b1;
        if (ctrl.last) begin
          ctrl.clear_sums = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 3'd1;
          state_next = S_DSTART;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/kmcq_datapath.sv
// Datapath: centroid table, cluster sums, distance search and mean divider.
`default_nettype none
module kmcq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  kmcq_pkg::item_t    item,
  input  kmcq_pkg::ctrl_t    ctrl,
  output kmcq_pkg::stat_t    stat,
  output logic               strobe,
  output kmcq_pkg::result_t  result
);
  localparam int unsigned SW = kmcq_pkg::SumW;
  localparam int unsigned CW = kmcq_pkg::CntW;
  localparam int unsigned PW = $clog2(kmcq_pkg::MaxPixels + 1);

  logic [23:0]   cent [kmcq_pkg::MaxK];
  logic [SW-1:0] sr [kmcq_pkg::MaxK];
  logic [SW-1:0] sg [kmcq_pkg::MaxK];
  logic [SW-1:0] sb [kmcq_pkg::MaxK];
  logic [CW-1:0] cnt [kmcq_pkg::MaxK];
  logic [PW-1:0] pass;
  kmcq_pkg::item_t cur;
  logic [2:0]    best;
  logic [17:0]   best_d;

  // Squared distance of the current centroid from the pixel.
  logic [8:0]  dr, dg, db;
  logic [17:0] d;
  logic [23:0] c;
  always_comb begin
    c = cent[ctrl.idx];
    dr = {1'b0, cur.red} - {1'b0, c[23:16]};
    dg = {1'b0, cur.green} - {1'b0, c[15:8]};
    db = {1'b0, cur.blue} - {1'b0, c[7:0]};
    d = 18'($signed(dr) * $signed(dr)) + 18'($signed(dg) * $signed(dg))
      + 18'($signed(db) * $signed(db));
  end

  // Restoring divider, one quotient bit per cycle, three channels at once.
  logic [SW-1:0] qr, qg, qb;
  logic [CW:0]   rr, rg, rb;
  logic [4:0]    bitn;
  logic [CW:0]   tr, tg, tb;
  logic [CW-1:0] den;
  assign den = cnt[ctrl.idx];
  always_comb begin
    tr = {rr[CW-1:0], qr[SW-1]};
    tg = {rg[CW-1:0], qg[SW-1]};
    tb = {rb[CW-1:0], qb[SW-1]};
  end
  assign stat.div_done = (bitn == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kmcq_pkg::MaxK; i++) begin
        cent[i] <= '0;
        sr[i] <= '0;
        sg[i] <= '0;
        sb[i] <= '0;
        cnt[i] <= '0;
      end
      pass <= '0;
      strobe <= 1'b0;
      bitn <= '0;
    end else begin
      strobe <= ctrl.emit_pixel | ctrl.write_mean;
      if (ctrl.load) cent[item.cluster_select] <= {item.red, item.green, item.blue};
      if (ctrl.accum && pass < PW'(kmcq_pkg::MaxPixels)) begin
        sr[best] <= sr[best] + SW'(cur.red);
        sg[best] <= sg[best] + SW'(cur.green);
        sb[best] <= sb[best] + SW'(cur.blue);
        cnt[best] <= cnt[best] + CW'(1);
        pass <= pass + PW'(1);
      end
      if (ctrl.div_start) bitn <= 5'(SW);
      else if (ctrl.div_step && bitn != 5'd0) bitn <= bitn - 5'd1;
      if (ctrl.write_mean) begin
        cent[ctrl.idx] <= (den == '0) ? 24'd0 : {qr[7:0], qg[7:0], qb[7:0]};
      end
      if (ctrl.clear_sums) begin
        for (int i = 0; i < kmcq_pkg::MaxK; i++) begin
          sr[i] <= '0;
          sg[i] <= '0;
          sb[i] <= '0;
          cnt[i] <= '0;
        end
        pass <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) cur <= item;
    if (ctrl.dist_clear) begin
      best <= 3'd0;
      best_d <= '1;
    end
    if (ctrl.dist_step && (ctrl.idx == 3'd0 || d < best_d)) begin
      best <= ctrl.idx;
      best_d <= d;
    end
    if (ctrl.div_start) begin
      qr <= sr[ctrl.idx];
      qg <= sg[ctrl.idx];
      qb <= sb[ctrl.idx];
      rr <= '0;
      rg <= '0;
      rb <= '0;
    end else if (ctrl.div_step && bitn != 5'd0) begin
      if (tr >= {1'b0, den}) begin
        rr <= tr - {1'b0, den};
        qr <= {qr[SW-2:0], 1'b1};
      end else begin
        rr <= tr;
        qr <= {qr[SW-2:0], 1'b0};
      end
      if (tg >= {1'b0, den}) begin
        rg <= tg - {1'b0, den};
        qg <= {qg[SW-2:0], 1'b1};
      end else begin
        rg <= tg;
        qg <= {qg[SW-2:0], 1'b0};
      end
      if (tb >= {1'b0, den}) begin
        rb <= tb - {1'b0, den};
        qb <= {qb[SW-2:0], 1'b1};
      end else begin
        rb <= tb;
        qb <= {qb[SW-2:0], 1'b0};
      end
    end
    if (ctrl.emit_pixel) begin
      result.result_kind <= kmcq_pkg::KindPixel;
      result.cluster_index <= best;
      {result.out_red, result.out_green, result.out_blue} <= cent[best];
      result.last_result <= 1'b1;
    end
    if (ctrl.write_mean) begin
      result.result_kind <= kmcq_pkg::KindCentroid;
      result.cluster_index <= ctrl.idx;
      {result.out_red, result.out_green, result.out_blue} <=
        (den == '0) ? 24'd0 : {qr[7:0], qg[7:0], qb[7:0]};
      result.last_result <= ctrl.last;
    end
  end
endmodule
`default_nettype wire

### rtl/core/kmeans_color_quantizer_unit.sv
// Top level of the k-means colour quantiser.
// A load transaction writes one centroid and gives no result. A pixel transaction compares
// one centroid per cycle and gives one result strobe. An update transaction runs the
// bit-serial mean divider once per cluster and gives K result strobes. Results are shown
// for exactly one cycle each on done; the receiver cannot stall, so it must take every
// strobe. active_clusters must be written only while idle; the block does not enforce it.
`default_nettype none
module kmeans_color_quantizer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  kmcq_pkg::item_t     item,
  output logic                done,
  output kmcq_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);
  logic [3:0] active_clusters;
  logic [3:0] k_eff;
  kmcq_pkg::ctrl_t ctrl;
  kmcq_pkg::stat_t stat;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) active_clusters <= 4'd8;
    else if (cfg_valid && cfg_ready) active_clusters <= cfg_data;
  end
  assign k_eff = (active_clusters == 4'd0) ? 4'd1 :
                 (active_clusters > 4'(kmcq_pkg::MaxK)) ? 4'(kmcq_pkg::MaxK) : active_clusters;

  kmcq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .item(item), .k_eff(k_eff),
    .stat(stat), .busy(busy), .ctrl(ctrl)
  );

  kmcq_datapath u_dp (
    .clk(clk), .rst(rst), .item(item), .ctrl(ctrl), .stat(stat),
    .strobe(done), .result(result)
  );

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !done || $past(ctrl.write_mean) || $past(ctrl.emit_pixel))
    else $error("result strobe without work");
  a_pixel_last: assert property (@(posedge clk) disable iff (rst)
    done && result.result_kind == kmcq_pkg::KindPixel |-> result.last_result)
    else $error("pixel result not flagged last");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    done |-> {1'b0, result.cluster_index} < k_eff)
    else $error("result index beyond K");
endmodule
`default_nettype wire
